### rtl/llace_pkg.sv
`timescale 1ns / 1ps
package llace_pkg;

	localparam int MaxSideDefault = 64;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_READ   = 2'd1,
		OP_EVOLVE = 2'd2,
		OP_COMMIT = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_LIVE   = 3'd0,
		REG_BORN   = 3'd1,
		REG_WRAP   = 3'd2,
		REG_COLS   = 3'd3,
		REG_ROWS   = 3'd4
	} reg_idx_t;

	localparam logic [2:0] WRAP_PLANE = 3'd0;
	localparam logic [2:0] WRAP_RING  = 3'd1;
	localparam logic [2:0] WRAP_MOB   = 3'd2;
	localparam logic [2:0] WRAP_TORUS = 3'd3;
	localparam logic [2:0] WRAP_SPH   = 3'd4;
	localparam logic [2:0] WRAP_KLEIN = 3'd5;
	localparam logic [2:0] WRAP_PROJ  = 3'd6;

	// sphere edge codes: left, right, top, bottom
	localparam logic [3:0] SPH_TL = 4'hA;
	localparam logic [3:0] SPH_BR = 4'h5;
	localparam logic [3:0] SPH_BL = 4'h9;
	localparam logic [3:0] SPH_L  = 4'h8;
	localparam logic [3:0] SPH_TR = 4'h6;
	localparam logic [3:0] SPH_R  = 4'h4;
	localparam logic [3:0] SPH_T  = 4'h2;
	localparam logic [3:0] SPH_B  = 4'h1;

	typedef struct packed {
		logic [1:0] operation;
		logic [6:0] column;
		logic [6:0] row;
		logic       cell_value;
	} in_item_t;

	typedef struct packed {
		logic       cell_state;
		logic [3:0] neighbour_count;
		logic       status;
	} out_item_t;

	typedef struct packed {
		logic [2:0] index;
		logic [8:0] data;
	} cfg_item_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_NEIGH,
		ST_CENTRE,
		ST_FINISH,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clear_en;
		logic load;
		logic issue;
		logic centre;
		logic finish;
		logic flip;
		logic [2:0] nidx;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_done;
		logic bad;
		logic evolve;
		logic commit;
	} stat_t;

endpackage

### rtl/llace_ram.sv
`timescale 1ns / 1ps
module llace_ram #(
	parameter int Width = 1,
	parameter int Depth = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

### rtl/llace_datapath.sv
`timescale 1ns / 1ps
module llace_datapath import llace_pkg::*; #(
	parameter int MaxSide = MaxSideDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	input  in_item_t  item,
	input  logic      cfg_we,
	input  cfg_item_t cfg,
	output stat_t     stat,
	output out_item_t result
);
	localparam int SW = $clog2(MaxSide);
	localparam int AW = 2 * SW;
	localparam int CW = SW + 2;
	localparam int Depth = 1 << AW;
	localparam logic [AW:0] Cells = (AW+1)'(Depth);

	logic [8:0] live_q, born_q;
	logic [2:0] wrap_q;
	logic [6:0] cols_q, rows_q;
	logic       cur_q;
	logic [AW:0] clr_q;
	logic [1:0] opq_q;
	logic [CW-1:0] c_q, r_q;
	logic       val_q, bad_q;
	logic [3:0] n_q;
	logic       pend_q, pend_ok_q;
	out_item_t  res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			born_q <= '0;
			wrap_q <= WRAP_PLANE;
			cols_q <= 7'd64;
			rows_q <= 7'd64;
		end else if (cfg_we) begin
			case (cfg.index)
				REG_LIVE: live_q <= cfg.data;
				REG_BORN: born_q <= cfg.data;
				REG_WRAP: wrap_q <= cfg.data[2:0];
				REG_COLS: cols_q <= cfg.data[6:0];
				REG_ROWS: rows_q <= cfg.data[6:0];
				default: ;
			endcase
		end
	end

	// effective board size
	logic [CW-1:0] w, h;
	always_comb begin
		if (cols_q == 7'd0) w = CW'(1);
		else if ({2'b0, cols_q} > 9'(MaxSide)) w = CW'(MaxSide);
		else w = CW'(cols_q);
		if (rows_q == 7'd0) h = CW'(1);
		else if ({2'b0, rows_q} > 9'(MaxSide)) h = CW'(MaxSide);
		else h = CW'(rows_q);
	end

	logic in_bad;
	assign in_bad = (item.column == 7'd0) || ({1'b0, item.column} > 8'(w))
		|| (item.row == 7'd0) || ({1'b0, item.row} > 8'(h));

	assign stat.bad = bad_q;
	assign stat.evolve = (opq_q == OP_EVOLVE);
	assign stat.commit = (opq_q == OP_COMMIT);
	assign stat.clear_done = (clr_q == Cells - (AW+1)'(1));

	// neighbour position for this step
	logic [CW-1:0] nc, nr, mc, mr;
	logic le, re, te, be, ovc, ovr, dead;
	logic [3:0] sph;
	always_comb begin
		case (cmd.nidx)
			3'd0: begin nc = c_q - CW'(1); nr = r_q - CW'(1); end
			3'd1: begin nc = c_q;          nr = r_q - CW'(1); end
			3'd2: begin nc = c_q + CW'(1); nr = r_q - CW'(1); end
			3'd3: begin nc = c_q - CW'(1); nr = r_q;          end
			3'd4: begin nc = c_q + CW'(1); nr = r_q;          end
			3'd5: begin nc = c_q - CW'(1); nr = r_q + CW'(1); end
			3'd6: begin nc = c_q;          nr = r_q + CW'(1); end
			default: begin nc = c_q + CW'(1); nr = r_q + CW'(1); end
		endcase
		le = (nc == '0);
		re = (nc > w);
		te = (nr == '0);
		be = (nr > h);
		ovc = le | re;
		ovr = te | be;
		sph = {le, re, te, be};
		mc = nc;
		mr = nr;
		dead = 1'b0;
		if (ovc || ovr) begin
			case (wrap_q)
				WRAP_RING: if (ovc) mc = le ? w : CW'(1);
				WRAP_MOB: if (ovc) begin
					mc = le ? w : CW'(1);
					mr = h + CW'(1) - nr;
				end
				WRAP_TORUS: begin
					if (ovc) mc = le ? w : CW'(1);
					if (ovr) mr = te ? h : CW'(1);
				end
				WRAP_SPH: begin
					case (sph)
						SPH_TL, SPH_BR: dead = 1'b1;
						SPH_BL: begin mc = w; mr = CW'(1); end
						SPH_L:  begin mc = nr; mr = CW'(1); end
						SPH_TR: begin mc = CW'(1); mr = h; end
						SPH_R:  begin mc = nr; mr = h; end
						SPH_T:  begin mc = CW'(1); mr = nc; end
						SPH_B:  begin mc = w; mr = nc; end
						default: ;
					endcase
				end
				WRAP_KLEIN: begin
					if (ovc) mc = le ? w : CW'(1);
					if (ovr) mr = te ? h : CW'(1);
					if (ovc) mr = h + CW'(1) - mr;
				end
				WRAP_PROJ: begin
					if (ovc) mc = le ? w : CW'(1);
					if (ovr) mc = w + CW'(1) - mc;
					if (ovr) mr = te ? h : CW'(1);
					if (ovc) mr = h + CW'(1) - mr;
				end
				default: ;
			endcase
		end
		if (mc == '0 || mc > w || mr == '0 || mr > h) dead = 1'b1;
	end

	// memory addressing
	logic [AW-1:0] addr, caddr;
	logic we0, we1, wd, rd0, rd1, rd;
	assign caddr = {SW'(r_q - CW'(1)), SW'(c_q - CW'(1))};
	logic evo_bit;
	// centre read is on rd during the finish cycle
	assign evo_bit = (rd & live_q[n_q]) | born_q[n_q];

	always_comb begin
		addr = caddr;
		we0 = 1'b0;
		we1 = 1'b0;
		wd = 1'b0;
		if (cmd.clear_en) begin
			addr = clr_q[AW-1:0];
			we0 = 1'b1;
			we1 = 1'b1;
		end else if (cmd.issue && !cmd.centre) begin
			addr = {SW'(mr - CW'(1)), SW'(mc - CW'(1))};
		end else if (cmd.finish && !bad_q) begin
			wd = evo_bit;
			if (opq_q == OP_EVOLVE) begin
				we0 = cur_q;
				we1 = !cur_q;
			end else if (opq_q == OP_WRITE) begin
				wd = val_q;
				we0 = !cur_q;
				we1 = cur_q;
			end
		end
	end

	llace_ram #(.Width(1), .Depth(Depth)) u_ram0 (
		.clk(clk), .we(we0), .addr(addr), .wdata(wd), .rdata(rd0));
	llace_ram #(.Width(1), .Depth(Depth)) u_ram1 (
		.clk(clk), .we(we1), .addr(addr), .wdata(wd), .rdata(rd1));
	assign rd = cur_q ? rd1 : rd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			cur_q <= 1'b0;
			opq_q <= OP_COMMIT;
			bad_q <= 1'b0;
			n_q <= '0;
			pend_q <= 1'b0;
			pend_ok_q <= 1'b0;
		end else begin
			if (cmd.clear_en) clr_q <= clr_q + (AW+1)'(1);
			if (cmd.flip) cur_q <= !cur_q;
			if (cmd.load) begin
				opq_q <= item.operation;
				bad_q <= in_bad;
				n_q <= '0;
			end
			// read data of the previous issue arrives now
			pend_q <= cmd.issue;
			pend_ok_q <= cmd.issue && (cmd.centre || !dead);
			if (pend_q && !cmd.finish) begin
				if (pend_ok_q && rd) n_q <= n_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			c_q <= CW'(item.column);
			r_q <= CW'(item.row);
			val_q <= item.cell_value;
		end
		if (cmd.finish) begin
			res_q.status <= bad_q && (opq_q != OP_COMMIT);
			res_q.neighbour_count <= '0;
			res_q.cell_state <= 1'b0;
			if (!bad_q && opq_q == OP_READ) res_q.cell_state <= rd;
			if (!bad_q && opq_q == OP_EVOLVE) begin
				res_q.neighbour_count <= n_q;
				res_q.cell_state <= (rd & live_q[n_q]) | born_q[n_q];
			end
		end
	end
	assign result = res_q;
endmodule

### rtl/llace_ctrl.sv
`timescale 1ns / 1ps
module llace_ctrl import llace_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	output logic  out_valid,
	input  logic  out_stall,
	input  stat_t stat,
	output cmd_t  cmd
);
	state_t state_q, state_d;
	logic [2:0] k_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (stat.clear_done) state_d = ST_IDLE;
			ST_IDLE: if (in_valid) state_d = ST_CENTRE;
			ST_CENTRE: begin
				if (stat.evolve && !stat.bad) state_d = ST_NEIGH;
				else state_d = ST_FINISH;
			end
			// counter wraps to zero after the last neighbour: centre read
			ST_NEIGH: if (k_q == 3'd0) state_d = ST_FINISH;
			ST_FINISH: state_d = ST_OUT;
			ST_OUT: if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.nidx = k_q;
		in_stall = (state_q != ST_IDLE);
		out_valid = (state_q == ST_OUT);
		case (state_q)
			ST_CLEAR: cmd.clear_en = 1'b1;
			ST_IDLE: cmd.load = in_valid;
			ST_CENTRE: begin
				// neighbours first for evolve, centre read last
				if (!(stat.evolve && !stat.bad)) begin
					cmd.issue = 1'b1;
					cmd.centre = 1'b1;
				end else begin
					cmd.issue = 1'b1;
				end
			end
			ST_NEIGH: begin
				cmd.issue = 1'b1;
				cmd.centre = (k_q == 3'd0);
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				cmd.flip = stat.commit;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			k_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CENTRE || state_q == ST_NEIGH) k_q <= k_q + 3'd1;
			else k_q <= '0;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_stall) |=> state_q == ST_OUT)
		else $error("result dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_CENTRE)
		else $error("load did not start work");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH |=> out_valid)
		else $error("finish without result");
endmodule

### rtl/life_like_automaton_cell_engine_core.sv
`timescale 1ns / 1ps
// Life-like automaton cell engine: two single-port bit planes, one item at a time.
// After reset both planes are swept clear, one cell a cycle (4096 cells at the
// default MAX_SIDE of 64) before the first item is taken. An item is loaded, its
// plane reads issued, then finished and its result held until out_stall is low.
// Write, read, commit and out-of-range evolve read the centre cell only; evolve
// reads nine cells of the single-port plane memory (eight neighbours then centre).
module life_like_automaton_cell_engine_core import llace_pkg::*; #(
	parameter int MAX_SIDE = MaxSideDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  cfg_item_t cfg_data
);
	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	llace_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd));

	llace_datapath #(.MaxSide(MAX_SIDE)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .item(in_data),
		.cfg_we(cfg_valid), .cfg(cfg_data), .stat(stat), .result(out_data));
endmodule
